FILE: src/efcc_pkg.sv
// Shared types and constants for the frame classifier and event counters.
// No dependencies; every other file in src except efcc_ram imports this package.
package efcc_pkg;

  // Sizes
  localparam int MAX_FRAME_BYTES = 1518;
  localparam int CNT_BITS        = 32;
  localparam int NUM_CNT         = 18;
  localparam int POS_BITS        = $clog2(MAX_FRAME_BYTES + 1);
  localparam int ADDR_BITS       = $clog2(NUM_CNT);
  localparam int LIMIT_BITS      = 16;

  // Capture offsets within the frame
  localparam int OFS_ETYPE_HI = 12;
  localparam int OFS_ETYPE_LO = 13;
  localparam int OFS_V6_NH    = 20;
  localparam int OFS_V4_PROTO = 23;
  localparam int OFS_SPORT_HI = 34;
  localparam int OFS_SPORT_LO = 35;
  localparam int OFS_DPORT_HI = 36;
  localparam int OFS_DPORT_LO = 37;

  // Request and response kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_READ = 1'b1;
  localparam logic RESP_FRAME = 1'b0;
  localparam logic RESP_COUNT = 1'b1;

  // Network classes
  localparam logic [1:0] NET_OTHER = 2'd0;
  localparam logic [1:0] NET_IPV4  = 2'd1;
  localparam logic [1:0] NET_ARP   = 2'd2;
  localparam logic [1:0] NET_IPV6  = 2'd3;

  // Transport classes
  localparam logic [2:0] TRN_NONE  = 3'd0;
  localparam logic [2:0] TRN_ICMP4 = 3'd1;
  localparam logic [2:0] TRN_ICMP6 = 3'd2;
  localparam logic [2:0] TRN_TCP   = 3'd3;
  localparam logic [2:0] TRN_UDP   = 3'd4;

  // Application classes
  localparam logic [2:0] APP_NONE  = 3'd0;
  localparam logic [2:0] APP_SMTP  = 3'd1;
  localparam logic [2:0] APP_HTTP  = 3'd2;
  localparam logic [2:0] APP_HTTPS = 3'd3;
  localparam logic [2:0] APP_DHCP  = 3'd4;
  localparam logic [2:0] APP_DNS   = 3'd5;

  // Protocol field values
  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_ARP  = 16'h0806;
  localparam logic [15:0] ETH_IPV6 = 16'h86dd;
  localparam logic [7:0]  IP_ICMP4 = 8'h01;
  localparam logic [7:0]  IP_TCP   = 8'h06;
  localparam logic [7:0]  IP_UDP   = 8'h11;
  localparam logic [7:0]  IP_ICMP6 = 8'h3a;
  localparam logic [15:0] PORT_SMTP  = 16'h0019;
  localparam logic [15:0] PORT_HTTP  = 16'h0050;
  localparam logic [15:0] PORT_HTTPS = 16'h01bb;
  localparam logic [15:0] PORT_DHCP  = 16'h0043;
  localparam logic [15:0] PORT_DNS   = 16'h0035;

  // Counter map
  localparam logic [ADDR_BITS-1:0] CNT_TOTAL   = ADDR_BITS'(0);
  localparam logic [ADDR_BITS-1:0] CNT_IPV4    = ADDR_BITS'(1);
  localparam logic [ADDR_BITS-1:0] CNT_IPV6    = ADDR_BITS'(2);
  localparam logic [ADDR_BITS-1:0] CNT_ICMP4   = ADDR_BITS'(3);
  localparam logic [ADDR_BITS-1:0] CNT_ICMP6   = ADDR_BITS'(4);
  localparam logic [ADDR_BITS-1:0] CNT_ARP     = ADDR_BITS'(5);
  localparam logic [ADDR_BITS-1:0] CNT_TCP     = ADDR_BITS'(6);
  localparam logic [ADDR_BITS-1:0] CNT_UDP     = ADDR_BITS'(7);
  localparam logic [ADDR_BITS-1:0] CNT_SMTP_TX = ADDR_BITS'(8);
  localparam logic [ADDR_BITS-1:0] CNT_SMTP_RX = ADDR_BITS'(9);
  localparam logic [ADDR_BITS-1:0] CNT_HTTP_TX = ADDR_BITS'(10);
  localparam logic [ADDR_BITS-1:0] CNT_HTTP_RX = ADDR_BITS'(11);
  localparam logic [ADDR_BITS-1:0] CNT_HTTPS_TX = ADDR_BITS'(12);
  localparam logic [ADDR_BITS-1:0] CNT_HTTPS_RX = ADDR_BITS'(13);
  localparam logic [ADDR_BITS-1:0] CNT_DHCP_TX = ADDR_BITS'(14);
  localparam logic [ADDR_BITS-1:0] CNT_DHCP_RX = ADDR_BITS'(15);
  localparam logic [ADDR_BITS-1:0] CNT_DNS_TX  = ADDR_BITS'(16);
  localparam logic [ADDR_BITS-1:0] CNT_DNS_RX  = ADDR_BITS'(17);
  localparam logic [4:0] IDX_TOP_APP = 5'd18;

  typedef logic [CNT_BITS-1:0] cnt_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [4:0] counter_index;
  } in_item_t;

  typedef struct packed {
    logic        resp_kind;
    logic [1:0]  network_class;
    logic [2:0]  transport_class;
    logic [2:0]  app_by_dst_port;
    logic [2:0]  app_by_src_port;
    logic        frame_ignored;
    logic [31:0] counter_value;
  } out_item_t;

  // Header fields captured from one frame
  typedef struct packed {
    logic [15:0] ether_type;
    logic [7:0]  v6_next_hdr;
    logic [7:0]  v4_proto;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } hdr_t;

endpackage

FILE: src/efcc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module efcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 18
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/efcc_capture.sv
// Byte position tracking and header field capture for the frame in progress.
// Depends on efcc_pkg.
module efcc_capture import efcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_acc,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output hdr_t       hdr_nxt
);

  logic [POS_BITS-1:0] pos_r, pos_nxt;
  hdr_t                hdr_r;

  // Merge the incoming byte into the captured fields
  always_comb begin
    hdr_nxt = hdr_r;
    pos_nxt = pos_r;
    if (pos_r < POS_BITS'(MAX_FRAME_BYTES)) begin
      pos_nxt = pos_r + 1'b1;
      case (pos_r)
        POS_BITS'(OFS_ETYPE_HI): hdr_nxt.ether_type[15:8] = data_byte;
        POS_BITS'(OFS_ETYPE_LO): hdr_nxt.ether_type[7:0]  = data_byte;
        POS_BITS'(OFS_V6_NH):    hdr_nxt.v6_next_hdr      = data_byte;
        POS_BITS'(OFS_V4_PROTO): hdr_nxt.v4_proto         = data_byte;
        POS_BITS'(OFS_SPORT_HI): hdr_nxt.src_port[15:8]   = data_byte;
        POS_BITS'(OFS_SPORT_LO): hdr_nxt.src_port[7:0]    = data_byte;
        POS_BITS'(OFS_DPORT_HI): hdr_nxt.dst_port[15:8]   = data_byte;
        POS_BITS'(OFS_DPORT_LO): hdr_nxt.dst_port[7:0]    = data_byte;
        default: ;
      endcase
    end
  end

  // Advance on each byte, clear at frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hdr_r <= '0;
    end else if (byte_acc) begin
      if (last_byte) begin
        pos_r <= '0;
        hdr_r <= '0;
      end else begin
        pos_r <= pos_nxt;
        hdr_r <= hdr_nxt;
      end
    end
  end

endmodule

FILE: src/efcc_engine.sv
// Counter sequencer: read-modify-write of the event counter RAM at frame end,
// counter reads and the top application scan. Depends on efcc_pkg, efcc_ram.
module efcc_engine import efcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start_frame,
  input  logic                  start_read,
  input  logic [4:0]            rd_index,
  input  hdr_t                  hdr,
  input  logic [LIMIT_BITS-1:0] frame_limit,
  output logic                  idle,
  output logic                  res_valid,
  output out_item_t             res,
  input  logic                  res_take
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHK, ST_NEXT, ST_WR, ST_RDRET, ST_SCAN, ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0] net;
    logic [2:0] trn;
    logic [2:0] adst;
    logic [2:0] asrc;
  } cls_t;

  state_t                state_r, state_nxt;
  cls_t                  cls_r, cls_nxt;
  logic [ADDR_BITS-1:0]  bump_addr_r [4];
  logic [ADDR_BITS-1:0]  bump_addr_nxt [4];
  logic [3:0]            bump_vld_r, bump_vld_nxt;
  logic [2:0]            slot_r, slot_nxt;
  logic [ADDR_BITS-1:0]  addr_r, addr_nxt;
  cnt_t                  best_v_r, best_v_nxt;
  logic [2:0]            best_c_r, best_c_nxt;
  logic [2:0]            scan_app_r, scan_app_nxt;
  out_item_t             res_r, res_nxt;
  logic [NUM_CNT-1:0]    cnt_vld_r, cnt_vld_nxt;
  logic                  rvld_r, rvld_nxt;

  logic                  ram_we;
  logic [ADDR_BITS-1:0]  ram_waddr, ram_raddr;
  cnt_t                  ram_wdata, ram_rdata, rd_val;
  cls_t                  cls_new;

  efcc_ram #(.WIDTH(CNT_BITS), .DEPTH(NUM_CNT)) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic logic [2:0] tcp_app(logic [15:0] port);
    if (port == PORT_SMTP)  return APP_SMTP;
    if (port == PORT_HTTP)  return APP_HTTP;
    if (port == PORT_HTTPS) return APP_HTTPS;
    return APP_NONE;
  endfunction

  function automatic logic [2:0] udp_app(logic [15:0] port);
    if (port == PORT_DHCP) return APP_DHCP;
    if (port == PORT_DNS)  return APP_DNS;
    return APP_NONE;
  endfunction

  function automatic logic [ADDR_BITS-1:0] app_addr(logic [2:0] app, logic rx);
    case (app)
      APP_SMTP:  return rx ? CNT_SMTP_RX  : CNT_SMTP_TX;
      APP_HTTP:  return rx ? CNT_HTTP_RX  : CNT_HTTP_TX;
      APP_HTTPS: return rx ? CNT_HTTPS_RX : CNT_HTTPS_TX;
      APP_DHCP:  return rx ? CNT_DHCP_RX  : CNT_DHCP_TX;
      APP_DNS:   return rx ? CNT_DNS_RX   : CNT_DNS_TX;
      default:   return CNT_TOTAL;
    endcase
  endfunction

  function automatic logic [31:0] clamp32(cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hffff_ffff) ? 32'hffff_ffff : w[31:0];
  endfunction

  // Classify the finished frame's header
  always_comb begin
    cls_new = '0;
    case (hdr.ether_type)
      ETH_IPV4: begin
        cls_new.net = NET_IPV4;
        case (hdr.v4_proto)
          IP_ICMP4: cls_new.trn = TRN_ICMP4;
          IP_TCP: begin
            cls_new.trn  = TRN_TCP;
            cls_new.adst = tcp_app(hdr.dst_port);
            cls_new.asrc = tcp_app(hdr.src_port);
          end
          IP_UDP: begin
            cls_new.trn  = TRN_UDP;
            cls_new.adst = udp_app(hdr.dst_port);
            cls_new.asrc = udp_app(hdr.src_port);
          end
          default: ;
        endcase
      end
      ETH_ARP: cls_new.net = NET_ARP;
      ETH_IPV6: begin
        cls_new.net = NET_IPV6;
        case (hdr.v6_next_hdr)
          IP_ICMP6: cls_new.trn = TRN_ICMP6;
          IP_TCP:   cls_new.trn = TRN_TCP;
          IP_UDP:   cls_new.trn = TRN_UDP;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Invalid (never written) entries read as zero
  assign rd_val = rvld_r ? ram_rdata : '0;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cls_nxt       = cls_r;
    bump_addr_nxt = bump_addr_r;
    bump_vld_nxt  = bump_vld_r;
    slot_nxt      = slot_r;
    addr_nxt      = addr_r;
    best_v_nxt    = best_v_r;
    best_c_nxt    = best_c_r;
    scan_app_nxt  = scan_app_r;
    res_nxt       = res_r;
    cnt_vld_nxt   = cnt_vld_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = rd_val;
    ram_raddr     = CNT_TOTAL;

    case (state_r)
      ST_IDLE: begin
        if (start_frame) begin
          // Latch classes and the list of counters to bump, fetch the total
          cls_nxt = cls_new;
          case (cls_new.net)
            NET_IPV4: bump_addr_nxt[0] = CNT_IPV4;
            NET_ARP:  bump_addr_nxt[0] = CNT_ARP;
            default:  bump_addr_nxt[0] = CNT_IPV6;
          endcase
          case (cls_new.trn)
            TRN_ICMP4: bump_addr_nxt[1] = CNT_ICMP4;
            TRN_ICMP6: bump_addr_nxt[1] = CNT_ICMP6;
            TRN_TCP:   bump_addr_nxt[1] = CNT_TCP;
            default:   bump_addr_nxt[1] = CNT_UDP;
          endcase
          bump_addr_nxt[2] = app_addr(cls_new.adst, 1'b0);
          bump_addr_nxt[3] = app_addr(cls_new.asrc, 1'b1);
          bump_vld_nxt = {cls_new.asrc != APP_NONE, cls_new.adst != APP_NONE,
                          cls_new.trn != TRN_NONE, cls_new.net != NET_OTHER};
          ram_raddr = CNT_TOTAL;
          state_nxt = ST_CHK;
        end else if (start_read) begin
          res_nxt = '0;
          res_nxt.resp_kind = RESP_COUNT;
          if (rd_index < 5'(NUM_CNT)) begin
            ram_raddr = rd_index[ADDR_BITS-1:0];
            state_nxt = ST_RDRET;
          end else if (rd_index == IDX_TOP_APP) begin
            ram_raddr    = app_addr(APP_SMTP, 1'b0);
            scan_app_nxt = APP_SMTP;
            best_v_nxt   = '0;
            best_c_nxt   = APP_SMTP;
            state_nxt    = ST_SCAN;
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end

      ST_CHK: begin
        res_nxt = '0;
        res_nxt.resp_kind = RESP_FRAME;
        if (64'(rd_val) >= 64'(frame_limit) || rd_val == '1) begin
          // Drop the frame: no counter moves
          res_nxt.frame_ignored = 1'b1;
          state_nxt = ST_RESP;
        end else begin
          ram_we      = 1'b1;
          ram_waddr   = CNT_TOTAL;
          ram_wdata   = rd_val + 1'b1;
          cnt_vld_nxt[CNT_TOTAL] = 1'b1;
          res_nxt.network_class   = cls_r.net;
          res_nxt.transport_class = cls_r.trn;
          res_nxt.app_by_dst_port = cls_r.adst;
          res_nxt.app_by_src_port = cls_r.asrc;
          slot_nxt  = '0;
          state_nxt = ST_NEXT;
        end
      end

      ST_NEXT: begin
        if (slot_r == 3'd4) begin
          state_nxt = ST_RESP;
        end else if (bump_vld_r[slot_r[1:0]]) begin
          ram_raddr = bump_addr_r[slot_r[1:0]];
          addr_nxt  = bump_addr_r[slot_r[1:0]];
          state_nxt = ST_WR;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end

      ST_WR: begin
        // Saturating increment, write back
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = (rd_val == '1) ? rd_val : rd_val + 1'b1;
        cnt_vld_nxt[addr_r] = 1'b1;
        slot_nxt  = slot_r + 1'b1;
        state_nxt = ST_NEXT;
      end

      ST_RDRET: begin
        res_nxt.counter_value = clamp32(rd_val);
        state_nxt = ST_RESP;
      end

      ST_SCAN: begin
        // First strict maximum wins
        if (rd_val > best_v_r) begin
          best_v_nxt = rd_val;
          best_c_nxt = scan_app_r;
        end
        if (scan_app_r == APP_DNS) begin
          res_nxt.counter_value = 32'((rd_val > best_v_r) ? scan_app_r : best_c_r);
          state_nxt = ST_RESP;
        end else begin
          scan_app_nxt = scan_app_r + 1'b1;
          ram_raddr    = app_addr(scan_app_r + 1'b1, 1'b0);
        end
      end

      ST_RESP: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    rvld_nxt = (ram_raddr < ADDR_BITS'(NUM_CNT)) && cnt_vld_r[ram_raddr];
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_vld_r <= '0;
      rvld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_vld_r <= cnt_vld_nxt;
      rvld_r    <= rvld_nxt;
    end
    cls_r       <= cls_nxt;
    bump_addr_r <= bump_addr_nxt;
    bump_vld_r  <= bump_vld_nxt;
    slot_r      <= slot_nxt;
    addr_r      <= addr_nxt;
    best_v_r    <= best_v_nxt;
    best_c_r    <= best_c_nxt;
    scan_app_r  <= scan_app_nxt;
    res_r       <= res_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESP);
  assign res       = res_r;

  // Counter RAM is only written while a frame is being accounted
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_RESP) |-> !ram_we)
    else $error("counter write outside frame accounting");

  // An ignored frame carries no classes
  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.frame_ignored) |->
      (res.network_class == NET_OTHER && res.transport_class == TRN_NONE &&
       res.app_by_dst_port == APP_NONE && res.app_by_src_port == APP_NONE))
    else $error("ignored frame with class fields set");

  // A frame end always starts with the total counter check
  a_frame_checks_total: assert property (@(posedge clk) disable iff (!rst_n)
    (idle && start_frame) |=> (state_r == ST_CHK))
    else $error("frame end did not fetch the total counter");

  // Top application result is a valid application code
  a_top_app_code: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && state_nxt == ST_RESP) |=>
      (res.counter_value >= 32'(APP_SMTP) && res.counter_value <= 32'(APP_DNS)))
    else $error("top application code out of range");

endmodule

FILE: src/ethernet_frame_classify_count.sv
// Top level: Ethernet frame classifier with saturating event counters.
// Depends on efcc_pkg, efcc_capture, efcc_engine (and efcc_ram below it).
//
//   channel | ports                     | payload
//   --------+---------------------------+--------------------------
//   input   | in_valid / in_ready       | in_data  (in_item_t)
//   result  | out_valid / out_ready     | out_data (out_item_t)
//   config  | cfg_valid / cfg_ready     | cfg_data (frame limit, 16 bit)
//
// Bytes without the last mark leave the engine idle, so they stream at one
// per cycle while it is idle. A last byte makes the engine check the total
// counter, then read-modify-write each class counter bumped, one RAM entry at
// a time; an ignored frame skips these. A counter read fetches one entry, the
// top application scan the five application TX counters, an out-of-range
// index none. Reset is synchronous; the 18 counters clear at once through
// per-entry valid bits. A stalled result holds in the output register while
// the input side keeps taking bytes; a new frame end waits for it.
module ethernet_frame_classify_count import efcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LIMIT_BITS-1:0] cfg_data
);

  logic [LIMIT_BITS-1:0] limit_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  logic                  in_acc, byte_acc;
  logic                  eng_idle, res_valid, res_take;
  out_item_t             res;
  hdr_t                  hdr_nxt;

  assign in_ready  = eng_idle;
  assign in_acc    = in_valid && in_ready;
  assign byte_acc  = in_acc && (in_data.req_type == REQ_BYTE);
  assign cfg_ready = 1'b1;

  efcc_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (byte_acc),
    .data_byte (in_data.data_byte),
    .last_byte (in_data.last_byte),
    .hdr_nxt   (hdr_nxt)
  );

  efcc_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_frame (byte_acc && in_data.last_byte),
    .start_read  (in_acc && (in_data.req_type == REQ_READ)),
    .rd_index    (in_data.counter_index),
    .hdr         (hdr_nxt),
    .frame_limit (limit_r),
    .idle        (eng_idle),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take)
  );

  // Move a result into the output register when it is free or draining
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_BITS'(10);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
